@@ hw/rtl/slhp_pkg.sv @@
// slhp_pkg: shared constants for the sync layer packet header parser
// header field ids in stream order, flag and enable bit positions, register indexes and field widths
// no dependencies
`default_nettype none

package slhp_pkg;

	localparam int NUM_FIELDS = 19;
	localparam int FID_W      = 5;
	localparam int LEN_W      = 6;
	localparam int VAL_W      = 32;

	// header field ids, in the order they appear in the header
	localparam logic [FID_W-1:0] FID_AUS      = 5'd0;
	localparam logic [FID_W-1:0] FID_AUE      = 5'd1;
	localparam logic [FID_W-1:0] FID_OCR_FLAG = 5'd2;
	localparam logic [FID_W-1:0] FID_IDLE     = 5'd3;
	localparam logic [FID_W-1:0] FID_PAD      = 5'd4;
	localparam logic [FID_W-1:0] FID_PAD_BITS = 5'd5;
	localparam logic [FID_W-1:0] FID_PSN      = 5'd6;
	localparam logic [FID_W-1:0] FID_DP_FLAG  = 5'd7;
	localparam logic [FID_W-1:0] FID_DP       = 5'd8;
	localparam logic [FID_W-1:0] FID_OCR      = 5'd9;
	localparam logic [FID_W-1:0] FID_RAP      = 5'd10;
	localparam logic [FID_W-1:0] FID_AUSN     = 5'd11;
	localparam logic [FID_W-1:0] FID_DTS_FLAG = 5'd12;
	localparam logic [FID_W-1:0] FID_CTS_FLAG = 5'd13;
	localparam logic [FID_W-1:0] FID_IB_FLAG  = 5'd14;
	localparam logic [FID_W-1:0] FID_DTS      = 5'd15;
	localparam logic [FID_W-1:0] FID_CTS      = 5'd16;
	localparam logic [FID_W-1:0] FID_AUL      = 5'd17;
	localparam logic [FID_W-1:0] FID_IB       = 5'd18;
	localparam logic [FID_W-1:0] FID_END      = 5'd19;

	// bit positions in the flags result
	localparam int FLG_AUS  = 0;
	localparam int FLG_AUE  = 1;
	localparam int FLG_OCR  = 2;
	localparam int FLG_IDLE = 3;
	localparam int FLG_PAD  = 4;
	localparam int FLG_DP   = 5;
	localparam int FLG_RAP  = 6;
	localparam int FLG_DTS  = 7;
	localparam int FLG_CTS  = 8;
	localparam int FLG_IB   = 9;

	// bit positions in the flag_enables register
	localparam int EN_AUS  = 0;
	localparam int EN_AUE  = 1;
	localparam int EN_RAP  = 2;
	localparam int EN_PAD  = 3;
	localparam int EN_TS   = 4;
	localparam int EN_IDLE = 5;

	// configuration register indexes
	localparam logic [2:0] REG_FLAG_ENABLES     = 3'd0;
	localparam logic [2:0] REG_CLOCK_REF_LENGTH = 3'd1;
	localparam logic [2:0] REG_STAMP_LENGTH     = 3'd2;
	localparam logic [2:0] REG_AU_LENGTH_BITS   = 3'd3;
	localparam logic [2:0] REG_BITRATE_LENGTH   = 3'd4;
	localparam logic [2:0] REG_PRIORITY_LENGTH  = 3'd5;
	localparam logic [2:0] REG_AU_SEQ_LENGTH    = 3'd6;
	localparam logic [2:0] REG_PACKET_SEQ_LENGTH = 3'd7;

endpackage

`default_nettype wire

@@ hw/rtl/sync_layer_header_parser.sv @@
// sync_layer_header_parser: bit-serial parser for sync layer packet headers
// depends on slhp_pkg
//
// channel   direction  handshake             payload
// in        to block   in_valid / in_ready   data_byte, packet_start
// out       from block out_valid / out_ready flags .. header_bytes (11 fields)
// cfg       to block   cfg_write             cfg_index, cfg_data
//
// a header byte is accepted in S_WAIT and the header bits it holds are then shifted in one
// at a time in S_BITS; a field search (S_SEEK) runs at each packet start and after each
// field that ends in the byte. at the header's end S_EMIT loads the result. bytes outside
// a header are only accepted.
// the result is registered; the parser keeps taking bytes while it waits and
// only holds in S_EMIT when a second result is ready before the first was taken.
// reset clears configuration, control state and all field values.
`default_nettype none

module sync_layer_header_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	// input bytes
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        packet_start,
	// result
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [9:0]       flags,
	output logic [2:0]       padding_bits,
	output logic [30:0]      packet_seq_num,
	output logic [14:0]      degradation_prio,
	output logic [31:0]      clock_reference,
	output logic [30:0]      au_seq_num,
	output logic [31:0]      decode_stamp,
	output logic [31:0]      compose_stamp,
	output logic [31:0]      unit_length,
	output logic [31:0]      instant_bitrate,
	output logic [5:0]       header_bytes
);

	typedef enum logic [1:0] {
		S_WAIT,
		S_SEEK,
		S_BITS,
		S_EMIT
	} state_t;

	localparam int NF = slhp_pkg::NUM_FIELDS;
	localparam int FW = slhp_pkg::FID_W;
	localparam int LW = slhp_pkg::LEN_W;

	state_t state_q;

	// configuration
	logic [5:0] en_q;
	logic [5:0] ocr_len_q;
	logic [5:0] stamp_len_q;
	logic [5:0] aul_len_q;
	logic [5:0] ib_len_q;
	logic [3:0] dp_len_q;
	logic [4:0] ausn_len_q;
	logic [4:0] psn_len_q;

	// parse control
	logic          hdr_active_q;
	logic          fresh_q;
	logic [FW-1:0] phase_q;
	logic [FW-1:0] seek_from_q;
	logic [LW-1:0] bits_left_q;
	logic [3:0]    bit_cnt_q;
	logic [7:0]    byte_q;
	logic [31:0]   shift_q;
	logic [5:0]    byte_count_q;

	// header field values
	logic [9:0]  flag_q;
	logic [2:0]  pad_q;
	logic [30:0] psn_q;
	logic [14:0] dp_q;
	logic [31:0] ocr_q;
	logic [30:0] ausn_q;
	logic [31:0] dts_q;
	logic [31:0] cts_q;
	logic [31:0] aul_q;
	logic [31:0] ib_q;

	// result register
	logic        out_valid_q;
	logic [9:0]  flags_q;
	logic [2:0]  padding_bits_q;
	logic [30:0] packet_seq_num_q;
	logic [14:0] degradation_prio_q;
	logic [31:0] clock_reference_q;
	logic [30:0] au_seq_num_q;
	logic [31:0] decode_stamp_q;
	logic [31:0] compose_stamp_q;
	logic [31:0] unit_length_q;
	logic [31:0] instant_bitrate_q;
	logic [5:0]  header_bytes_q;

	logic [LW-1:0] len_c [NF];
	logic [NF-1:0] present_c;
	logic [NF-1:0] stop_c;
	logic [NF-1:0] cand_c;
	logic          hit_c;
	logic [FW-1:0] idx_c;
	logic          done_c;
	logic          bit_c;
	logic [31:0]   new_val_c;
	logic          in_acc;
	logic          out_free;
	logic          res_load;

	assign in_ready  = (state_q == S_WAIT);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign res_load  = (state_q == S_EMIT) && out_free;
	assign bit_c     = byte_q[7];
	assign new_val_c = {shift_q[30:0], bit_c};

	// field lengths given the flags read so far; zero means skipped
	always_comb begin
		len_c[slhp_pkg::FID_AUS]      = {5'd0, en_q[slhp_pkg::EN_AUS]};
		len_c[slhp_pkg::FID_AUE]      = {5'd0, en_q[slhp_pkg::EN_AUE]};
		len_c[slhp_pkg::FID_OCR_FLAG] = {5'd0, (ocr_len_q != 6'd0)};
		len_c[slhp_pkg::FID_IDLE]     = {5'd0, en_q[slhp_pkg::EN_IDLE]};
		len_c[slhp_pkg::FID_PAD]      = {5'd0, en_q[slhp_pkg::EN_PAD]};
		len_c[slhp_pkg::FID_PAD_BITS] = flag_q[slhp_pkg::FLG_PAD] ? 6'd3 : 6'd0;
		len_c[slhp_pkg::FID_PSN]      = {1'b0, psn_len_q};
		len_c[slhp_pkg::FID_DP_FLAG]  = {5'd0, (dp_len_q != 4'd0)};
		len_c[slhp_pkg::FID_DP]       = flag_q[slhp_pkg::FLG_DP] ? {2'd0, dp_len_q} : 6'd0;
		len_c[slhp_pkg::FID_OCR]      = flag_q[slhp_pkg::FLG_OCR] ? ocr_len_q : 6'd0;
		len_c[slhp_pkg::FID_RAP]      = {5'd0, en_q[slhp_pkg::EN_RAP]};
		len_c[slhp_pkg::FID_AUSN]     = {1'b0, ausn_len_q};
		len_c[slhp_pkg::FID_DTS_FLAG] = {5'd0, en_q[slhp_pkg::EN_TS]};
		len_c[slhp_pkg::FID_CTS_FLAG] = {5'd0, en_q[slhp_pkg::EN_TS]};
		len_c[slhp_pkg::FID_IB_FLAG]  = {5'd0, (ib_len_q != 6'd0)};
		len_c[slhp_pkg::FID_DTS]      = flag_q[slhp_pkg::FLG_DTS] ? stamp_len_q : 6'd0;
		len_c[slhp_pkg::FID_CTS]      = flag_q[slhp_pkg::FLG_CTS] ? stamp_len_q : 6'd0;
		len_c[slhp_pkg::FID_AUL]      = aul_len_q;
		len_c[slhp_pkg::FID_IB]       = flag_q[slhp_pkg::FLG_IB] ? ib_len_q : 6'd0;
	end

	// first present field at or after seek_from_q; a stop mark ends the header
	always_comb begin
		stop_c = '0;
		stop_c[slhp_pkg::FID_PSN] = flag_q[slhp_pkg::FLG_IDLE] ||
			(flag_q[slhp_pkg::FLG_PAD] && (pad_q == 3'd0));
		stop_c[slhp_pkg::FID_RAP] = !flag_q[slhp_pkg::FLG_AUS];
		for (int i = 0; i < NF; i++) begin
			present_c[i] = (len_c[i] != '0);
			cand_c[i]    = (present_c[i] || stop_c[i]) && (FW'(i) >= seek_from_q);
		end
		hit_c = 1'b0;
		idx_c = '0;
		for (int i = NF - 1; i >= 0; i--) begin
			if (cand_c[i]) begin
				hit_c = 1'b1;
				idx_c = FW'(i);
			end
		end
		done_c = !hit_c || stop_c[idx_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_WAIT;
			en_q               <= '0;
			ocr_len_q          <= '0;
			stamp_len_q        <= '0;
			aul_len_q          <= '0;
			ib_len_q           <= '0;
			dp_len_q           <= '0;
			ausn_len_q         <= '0;
			psn_len_q          <= '0;
			hdr_active_q       <= 1'b0;
			fresh_q            <= 1'b0;
			phase_q            <= '0;
			seek_from_q        <= '0;
			bits_left_q        <= '0;
			bit_cnt_q          <= '0;
			byte_q             <= '0;
			shift_q            <= '0;
			byte_count_q       <= '0;
			flag_q             <= '0;
			pad_q              <= '0;
			psn_q              <= '0;
			dp_q               <= '0;
			ocr_q              <= '0;
			ausn_q             <= '0;
			dts_q              <= '0;
			cts_q              <= '0;
			aul_q              <= '0;
			ib_q               <= '0;
			out_valid_q        <= 1'b0;
			flags_q            <= '0;
			padding_bits_q     <= '0;
			packet_seq_num_q   <= '0;
			degradation_prio_q <= '0;
			clock_reference_q  <= '0;
			au_seq_num_q       <= '0;
			decode_stamp_q     <= '0;
			compose_stamp_q    <= '0;
			unit_length_q      <= '0;
			instant_bitrate_q  <= '0;
			header_bytes_q     <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					slhp_pkg::REG_FLAG_ENABLES:      en_q        <= cfg_data;
					slhp_pkg::REG_CLOCK_REF_LENGTH:  ocr_len_q   <= cfg_data;
					slhp_pkg::REG_STAMP_LENGTH:      stamp_len_q <= cfg_data;
					slhp_pkg::REG_AU_LENGTH_BITS:    aul_len_q   <= cfg_data;
					slhp_pkg::REG_BITRATE_LENGTH:    ib_len_q    <= cfg_data;
					slhp_pkg::REG_PRIORITY_LENGTH:   dp_len_q    <= cfg_data[3:0];
					slhp_pkg::REG_AU_SEQ_LENGTH:     ausn_len_q  <= cfg_data[4:0];
					slhp_pkg::REG_PACKET_SEQ_LENGTH: psn_len_q   <= cfg_data[4:0];
					default: ;
				endcase
			end

			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_WAIT: begin
					if (in_acc) begin
						byte_q    <= data_byte;
						bit_cnt_q <= 4'd8;
						if (packet_start) begin
							// new packet drops any unfinished header
							flag_q       <= '0;
							pad_q        <= '0;
							psn_q        <= '0;
							dp_q         <= '0;
							ocr_q        <= '0;
							ausn_q       <= '0;
							dts_q        <= '0;
							cts_q        <= '0;
							aul_q        <= '0;
							ib_q         <= '0;
							byte_count_q <= '0;
							seek_from_q  <= slhp_pkg::FID_AUS;
							fresh_q      <= 1'b1;
							hdr_active_q <= 1'b0;
							state_q      <= S_SEEK;
						end else if (hdr_active_q) begin
							byte_count_q <= byte_count_q + 6'd1;
							state_q      <= S_BITS;
						end
					end
				end
				S_SEEK: begin
					if (done_c) begin
						hdr_active_q <= 1'b0;
						fresh_q      <= 1'b0;
						state_q      <= S_EMIT;
					end else begin
						phase_q      <= idx_c;
						bits_left_q  <= len_c[idx_c];
						shift_q      <= '0;
						hdr_active_q <= 1'b1;
						if (fresh_q) begin
							// first byte of the packet is counted once a field needs it
							fresh_q      <= 1'b0;
							byte_count_q <= byte_count_q + 6'd1;
							state_q      <= S_BITS;
						end else if (bit_cnt_q == 4'd0) begin
							state_q <= S_WAIT;
						end else begin
							state_q <= S_BITS;
						end
					end
				end
				S_BITS: begin
					shift_q     <= new_val_c;
					byte_q      <= {byte_q[6:0], 1'b0};
					bit_cnt_q   <= bit_cnt_q - 4'd1;
					bits_left_q <= bits_left_q - 6'd1;
					if (bits_left_q == 6'd1) begin
						case (phase_q)
							slhp_pkg::FID_AUS:      flag_q[slhp_pkg::FLG_AUS]  <= bit_c;
							slhp_pkg::FID_AUE:      flag_q[slhp_pkg::FLG_AUE]  <= bit_c;
							slhp_pkg::FID_OCR_FLAG: flag_q[slhp_pkg::FLG_OCR]  <= bit_c;
							slhp_pkg::FID_IDLE:     flag_q[slhp_pkg::FLG_IDLE] <= bit_c;
							slhp_pkg::FID_PAD:      flag_q[slhp_pkg::FLG_PAD]  <= bit_c;
							slhp_pkg::FID_PAD_BITS: pad_q  <= new_val_c[2:0];
							slhp_pkg::FID_PSN:      psn_q  <= new_val_c[30:0];
							slhp_pkg::FID_DP_FLAG:  flag_q[slhp_pkg::FLG_DP]   <= bit_c;
							slhp_pkg::FID_DP:       dp_q   <= new_val_c[14:0];
							slhp_pkg::FID_OCR:      ocr_q  <= new_val_c;
							slhp_pkg::FID_RAP:      flag_q[slhp_pkg::FLG_RAP]  <= bit_c;
							slhp_pkg::FID_AUSN:     ausn_q <= new_val_c[30:0];
							slhp_pkg::FID_DTS_FLAG: flag_q[slhp_pkg::FLG_DTS]  <= bit_c;
							slhp_pkg::FID_CTS_FLAG: flag_q[slhp_pkg::FLG_CTS]  <= bit_c;
							slhp_pkg::FID_IB_FLAG:  flag_q[slhp_pkg::FLG_IB]   <= bit_c;
							slhp_pkg::FID_DTS:      dts_q  <= new_val_c;
							slhp_pkg::FID_CTS:      cts_q  <= new_val_c;
							slhp_pkg::FID_AUL:      aul_q  <= new_val_c;
							slhp_pkg::FID_IB:       ib_q   <= new_val_c;
							default: ;
						endcase
						seek_from_q <= phase_q + 5'd1;
						state_q     <= S_SEEK;
					end else if (bit_cnt_q == 4'd1) begin
						state_q <= S_WAIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						flags_q            <= flag_q;
						padding_bits_q     <= pad_q;
						packet_seq_num_q   <= psn_q;
						degradation_prio_q <= dp_q;
						clock_reference_q  <= ocr_q;
						au_seq_num_q       <= ausn_q;
						decode_stamp_q     <= dts_q;
						compose_stamp_q    <= cts_q;
						unit_length_q      <= aul_q;
						instant_bitrate_q  <= ib_q;
						header_bytes_q     <= byte_count_q;
						state_q            <= S_WAIT;
					end
				end
				default: state_q <= S_WAIT;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign flags            = flags_q;
	assign padding_bits     = padding_bits_q;
	assign packet_seq_num   = packet_seq_num_q;
	assign degradation_prio = degradation_prio_q;
	assign clock_reference  = clock_reference_q;
	assign au_seq_num       = au_seq_num_q;
	assign decode_stamp     = decode_stamp_q;
	assign compose_stamp    = compose_stamp_q;
	assign unit_length      = unit_length_q;
	assign instant_bitrate  = instant_bitrate_q;
	assign header_bytes     = header_bytes_q;

	// shifting always has a field bit pending and a byte bit left
	a_bits_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BITS) |-> (bits_left_q != 6'd0) && (bit_cnt_q != 4'd0))
		else $error("bit shift with no field or byte bits left");

	// search never starts past the end of the field list
	a_seek_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEEK) |-> (seek_from_q <= slhp_pkg::FID_END))
		else $error("field search starts past the last field");

	// a packet start always leads to a field search
	a_start_seek: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && packet_start) |=> (state_q == S_SEEK))
		else $error("packet start did not start a field search");

	// loading a result closes the header
	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> out_valid_q && !hdr_active_q)
		else $error("result load did not close the header");

endmodule

`default_nettype wire

@@ bench/sl_header_checker.sv @@
// sl_header_checker: watches the byte and result channels of the sync layer header parser,
// predicts every header result from the accepted bytes and the written registers, and counts
// mismatches; depends on slhp_pkg
`timescale 1ns / 1ps

module sl_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        packet_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [9:0]  flags,
	input  logic [2:0]  padding_bits,
	input  logic [30:0] packet_seq_num,
	input  logic [14:0] degradation_prio,
	input  logic [31:0] clock_reference,
	input  logic [30:0] au_seq_num,
	input  logic [31:0] decode_stamp,
	input  logic [31:0] compose_stamp,
	input  logic [31:0] unit_length,
	input  logic [31:0] instant_bitrate,
	input  logic [5:0]  header_bytes,
	output int          fail_count,
	output int          pending,
	output logic        header_open
);

	typedef struct packed {
		logic [9:0]  flags;
		logic [2:0]  padding_bits;
		logic [30:0] packet_seq_num;
		logic [14:0] degradation_prio;
		logic [31:0] clock_reference;
		logic [30:0] au_seq_num;
		logic [31:0] decode_stamp;
		logic [31:0] compose_stamp;
		logic [31:0] unit_length;
		logic [31:0] instant_bitrate;
		logic [5:0]  header_bytes;
	} sl_header_t;

	// no header in progress: waiting for the next packet start
	localparam logic [slhp_pkg::FID_W-1:0] PH_WAIT = slhp_pkg::FID_END + 5'd1;

	// register copies
	logic [5:0] en_mask, ocr_len, stamp_len, aul_len, ib_len;
	logic [3:0] dp_len;
	logic [4:0] ausn_len, psn_len;

	// parse state
	logic [slhp_pkg::FID_W-1:0] field_id;
	int unsigned                bits_left;
	logic [32:0]                bit_shift;
	logic [5:0]                 byte_total;
	sl_header_t                 acc;

	sl_header_t expected_headers[$];
	sl_header_t want, got, hdr;

	function automatic int unsigned field_bits(logic [slhp_pkg::FID_W-1:0] id);
		case (id)
			slhp_pkg::FID_AUS:      return 32'(en_mask[slhp_pkg::EN_AUS]);
			slhp_pkg::FID_AUE:      return 32'(en_mask[slhp_pkg::EN_AUE]);
			slhp_pkg::FID_OCR_FLAG: return 32'(ocr_len != 6'd0);
			slhp_pkg::FID_IDLE:     return 32'(en_mask[slhp_pkg::EN_IDLE]);
			slhp_pkg::FID_PAD:      return 32'(en_mask[slhp_pkg::EN_PAD]);
			slhp_pkg::FID_PAD_BITS: return acc.flags[slhp_pkg::FLG_PAD] ? 32'd3 : 32'd0;
			slhp_pkg::FID_PSN:      return 32'(psn_len);
			slhp_pkg::FID_DP_FLAG:  return 32'(dp_len != 4'd0);
			slhp_pkg::FID_DP:       return acc.flags[slhp_pkg::FLG_DP] ? 32'(dp_len) : 32'd0;
			slhp_pkg::FID_OCR:      return acc.flags[slhp_pkg::FLG_OCR] ? 32'(ocr_len) : 32'd0;
			slhp_pkg::FID_RAP:      return 32'(en_mask[slhp_pkg::EN_RAP]);
			slhp_pkg::FID_AUSN:     return 32'(ausn_len);
			slhp_pkg::FID_DTS_FLAG: return 32'(en_mask[slhp_pkg::EN_TS]);
			slhp_pkg::FID_CTS_FLAG: return 32'(en_mask[slhp_pkg::EN_TS]);
			slhp_pkg::FID_IB_FLAG:  return 32'(ib_len != 6'd0);
			slhp_pkg::FID_DTS:      return acc.flags[slhp_pkg::FLG_DTS] ? 32'(stamp_len) : 32'd0;
			slhp_pkg::FID_CTS:      return acc.flags[slhp_pkg::FLG_CTS] ? 32'(stamp_len) : 32'd0;
			slhp_pkg::FID_AUL:      return 32'(aul_len);
			slhp_pkg::FID_IB:       return acc.flags[slhp_pkg::FLG_IB] ? 32'(ib_len) : 32'd0;
			default:                return 32'd0;
		endcase
	endfunction

	// move to the first field at or after id that has bits, or end the header
	function automatic void open_field(logic [slhp_pkg::FID_W-1:0] id);
		logic [slhp_pkg::FID_W-1:0] f;
		f = id;
		while (1) begin
			// idle, or padding with no padding bits, cuts the header after the padding bits
			if (f == slhp_pkg::FID_PSN && (acc.flags[slhp_pkg::FLG_IDLE] ||
					(acc.flags[slhp_pkg::FLG_PAD] && acc.padding_bits == 3'd0)))
				f = slhp_pkg::FID_END;
			// no access unit start: nothing after the clock reference
			if (f == slhp_pkg::FID_RAP && !acc.flags[slhp_pkg::FLG_AUS])
				f = slhp_pkg::FID_END;
			if (f >= slhp_pkg::FID_END) begin
				field_id = slhp_pkg::FID_END;
				bits_left = 0;
				return;
			end
			if (field_bits(f) > 0)
				break;
			f++;
		end
		field_id = f;
		bits_left = field_bits(f);
		bit_shift = '0;
	endfunction

	function automatic void store_field(logic [slhp_pkg::FID_W-1:0] id, logic [31:0] v);
		case (id)
			slhp_pkg::FID_AUS:      acc.flags[slhp_pkg::FLG_AUS] = v[0];
			slhp_pkg::FID_AUE:      acc.flags[slhp_pkg::FLG_AUE] = v[0];
			slhp_pkg::FID_OCR_FLAG: acc.flags[slhp_pkg::FLG_OCR] = v[0];
			slhp_pkg::FID_IDLE:     acc.flags[slhp_pkg::FLG_IDLE] = v[0];
			slhp_pkg::FID_PAD:      acc.flags[slhp_pkg::FLG_PAD] = v[0];
			slhp_pkg::FID_PAD_BITS: acc.padding_bits = v[2:0];
			slhp_pkg::FID_PSN:      acc.packet_seq_num = v[30:0];
			slhp_pkg::FID_DP_FLAG:  acc.flags[slhp_pkg::FLG_DP] = v[0];
			slhp_pkg::FID_DP:       acc.degradation_prio = v[14:0];
			slhp_pkg::FID_OCR:      acc.clock_reference = v;
			slhp_pkg::FID_RAP:      acc.flags[slhp_pkg::FLG_RAP] = v[0];
			slhp_pkg::FID_AUSN:     acc.au_seq_num = v[30:0];
			slhp_pkg::FID_DTS_FLAG: acc.flags[slhp_pkg::FLG_DTS] = v[0];
			slhp_pkg::FID_CTS_FLAG: acc.flags[slhp_pkg::FLG_CTS] = v[0];
			slhp_pkg::FID_IB_FLAG:  acc.flags[slhp_pkg::FLG_IB] = v[0];
			slhp_pkg::FID_DTS:      acc.decode_stamp = v;
			slhp_pkg::FID_CTS:      acc.compose_stamp = v;
			slhp_pkg::FID_AUL:      acc.unit_length = v;
			slhp_pkg::FID_IB:       acc.instant_bitrate = v;
			default:                ;
		endcase
	endfunction

	function automatic sl_header_t close_header();
		acc.header_bytes = byte_total;
		field_id = PH_WAIT;
		return acc;
	endfunction

	// returns 1 when this byte completes a header, with the header in res
	function automatic bit parse_header_byte(input logic [7:0] d, input logic s,
			output sl_header_t res);
		int i;
		res = '0;
		if (s) begin
			// a new start drops any unfinished header
			acc = '0;
			byte_total = '0;
			open_field(slhp_pkg::FID_AUS);
			if (field_id == slhp_pkg::FID_END) begin
				res = close_header();
				return 1'b1;
			end
		end
		if (field_id >= slhp_pkg::FID_END)
			return 1'b0;
		byte_total = byte_total + 6'd1;
		for (i = 7; i >= 0; i--) begin
			// long fields keep their low 32 bits
			bit_shift = {bit_shift[31:0], d[i]};
			if (bits_left > 0)
				bits_left--;
			if (bits_left == 0) begin
				store_field(field_id, bit_shift[31:0]);
				open_field(field_id + 5'd1);
			end
			if (field_id == slhp_pkg::FID_END) begin
				res = close_header();
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void write_register(logic [2:0] idx, logic [5:0] v);
		case (idx)
			slhp_pkg::REG_FLAG_ENABLES:      en_mask = v;
			slhp_pkg::REG_CLOCK_REF_LENGTH:  ocr_len = v;
			slhp_pkg::REG_STAMP_LENGTH:      stamp_len = v;
			slhp_pkg::REG_AU_LENGTH_BITS:    aul_len = v;
			slhp_pkg::REG_BITRATE_LENGTH:    ib_len = v;
			slhp_pkg::REG_PRIORITY_LENGTH:   dp_len = v[3:0];
			slhp_pkg::REG_AU_SEQ_LENGTH:     ausn_len = v[4:0];
			slhp_pkg::REG_PACKET_SEQ_LENGTH: psn_len = v[4:0];
			default:                         ;
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_mask = '0;
			ocr_len = '0;
			stamp_len = '0;
			aul_len = '0;
			ib_len = '0;
			dp_len = '0;
			ausn_len = '0;
			psn_len = '0;
			field_id = PH_WAIT;
			bits_left = 0;
			bit_shift = '0;
			byte_total = '0;
			acc = '0;
			expected_headers.delete();
			fail_count = 0;
			pending = 0;
			header_open = 1'b0;
		end else begin
			if (cfg_write)
				write_register(cfg_index, cfg_data);
			if (out_valid && out_ready) begin
				got = {flags, padding_bits, packet_seq_num, degradation_prio, clock_reference,
					au_seq_num, decode_stamp, compose_stamp, unit_length, instant_bitrate,
					header_bytes};
				if (expected_headers.size() == 0) begin
					$display("%0t ns: header result with header_bytes %0d arrived, none expected",
						$time, header_bytes);
					fail_count++;
				end else begin
					want = expected_headers.pop_front();
					check_field("flags", 32'(want.flags), 32'(got.flags));
					check_field("padding_bits", 32'(want.padding_bits),
						32'(got.padding_bits));
					check_field("packet_seq_num", 32'(want.packet_seq_num),
						32'(got.packet_seq_num));
					check_field("degradation_prio", 32'(want.degradation_prio),
						32'(got.degradation_prio));
					check_field("clock_reference", want.clock_reference, got.clock_reference);
					check_field("au_seq_num", 32'(want.au_seq_num), 32'(got.au_seq_num));
					check_field("decode_stamp", want.decode_stamp, got.decode_stamp);
					check_field("compose_stamp", want.compose_stamp, got.compose_stamp);
					check_field("unit_length", want.unit_length, got.unit_length);
					check_field("instant_bitrate", want.instant_bitrate, got.instant_bitrate);
					check_field("header_bytes", 32'(want.header_bytes),
						32'(got.header_bytes));
				end
			end
			if (in_valid && in_ready) begin
				if (parse_header_byte(data_byte, packet_start, hdr))
					expected_headers.push_back(hdr);
			end
			pending = expected_headers.size();
			header_open = field_id < slhp_pkg::FID_END;
		end
	end

endmodule

@@ bench/testbench.sv @@
// testbench: drives packet bytes and register settings into sync_layer_header_parser under
// several idle patterns and gives the verdict; depends on slhp_pkg, the parser and
// sl_header_checker, which predicts and compares the header results
`timescale 1ns / 1ps

module testbench;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 64;
	localparam int QUIET_LIMIT  = 5000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 130;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [5:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        packet_start;
	logic        out_valid;
	logic        out_ready;
	logic [9:0]  flags;
	logic [2:0]  padding_bits;
	logic [30:0] packet_seq_num;
	logic [14:0] degradation_prio;
	logic [31:0] clock_reference;
	logic [30:0] au_seq_num;
	logic [31:0] decode_stamp;
	logic [31:0] compose_stamp;
	logic [31:0] unit_length;
	logic [31:0] instant_bitrate;
	logic [5:0]  header_bytes;

	int   mismatches;
	int   pending;
	logic header_open;

	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	bit   hold_req = 1'b0;
	int   sent_items = 0;
	int   quiet_cycles = 0;
	logic [5:0] en_now = '0;
	logic [5:0] ocr_now = '0;

	sync_layer_header_parser dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.packet_start     (packet_start),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.flags            (flags),
		.padding_bits     (padding_bits),
		.packet_seq_num   (packet_seq_num),
		.degradation_prio (degradation_prio),
		.clock_reference  (clock_reference),
		.au_seq_num       (au_seq_num),
		.decode_stamp     (decode_stamp),
		.compose_stamp    (compose_stamp),
		.unit_length      (unit_length),
		.instant_bitrate  (instant_bitrate),
		.header_bytes     (header_bytes)
	);

	sl_header_checker header_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.packet_start     (packet_start),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.flags            (flags),
		.padding_bits     (padding_bits),
		.packet_seq_num   (packet_seq_num),
		.degradation_prio (degradation_prio),
		.clock_reference  (clock_reference),
		.au_seq_num       (au_seq_num),
		.decode_stamp     (decode_stamp),
		.compose_stamp    (compose_stamp),
		.unit_length      (unit_length),
		.instant_bitrate  (instant_bitrate),
		.header_bytes     (header_bytes),
		.fail_count       (mismatches),
		.pending          (pending),
		.header_open      (header_open)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic hold_input(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic push_byte(input logic [7:0] d, input logic s);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < tx_idle_pct)
			gap++;
		sent_items++;
		if (gap > 0)
			hold_input(gap);
		in_valid <= 1'b1;
		data_byte <= d;
		packet_start <= s;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [5:0] v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
	endtask

	task automatic set_registers(logic [5:0] en, logic [5:0] ocr, logic [5:0] stamp,
			logic [5:0] aul, logic [5:0] ib, logic [5:0] dp, logic [5:0] ausn,
			logic [5:0] psn);
		write_reg(slhp_pkg::REG_FLAG_ENABLES, en);
		write_reg(slhp_pkg::REG_CLOCK_REF_LENGTH, ocr);
		write_reg(slhp_pkg::REG_STAMP_LENGTH, stamp);
		write_reg(slhp_pkg::REG_AU_LENGTH_BITS, aul);
		write_reg(slhp_pkg::REG_BITRATE_LENGTH, ib);
		write_reg(slhp_pkg::REG_PRIORITY_LENGTH, dp);
		write_reg(slhp_pkg::REG_AU_SEQ_LENGTH, ausn);
		write_reg(slhp_pkg::REG_PACKET_SEQ_LENGTH, psn);
		cfg_write <= 1'b0;
		en_now = en;
		ocr_now = ocr;
	endtask

	// finish any open header, then let the parser go quiet before registers change
	task automatic settle();
		while (header_open)
			push_byte(8'($urandom), 1'b0);
		hold_input(1);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// well-formed packet: leading flags biased toward long headers, random field content
	task automatic send_packet();
		logic [7:0] lead;
		int n;
		lead = 8'($urandom);
		n = 0;
		if (en_now[slhp_pkg::EN_AUS]) begin
			lead[7-n] = ($urandom_range(9) < 8);
			n++;
		end
		if (en_now[slhp_pkg::EN_AUE])
			n++;
		if (ocr_now != 0)
			n++;
		if (en_now[slhp_pkg::EN_IDLE]) begin
			lead[7-n] = ($urandom_range(9) == 0);
			n++;
		end
		// padding flag set: usually give it a nonzero bit count
		if (en_now[slhp_pkg::EN_PAD] && lead[7-n] && $urandom_range(4) != 0 &&
				lead[6-n -: 3] == 3'd0)
			lead[6-n -: 3] = 3'($urandom_range(7, 1));
		push_byte(lead, 1'b1);
		while (header_open)
			push_byte(8'($urandom), 1'b0);
		repeat ($urandom_range(2)) push_byte(8'($urandom), 1'b0);
	endtask

	function automatic logic [5:0] pick_length(int max_len);
		case ($urandom_range(3))
			0:       return 6'd0;
			1:       return 6'(max_len);
			2:       return 6'($urandom_range(max_len, 1));
			default: return 6'($urandom_range(8, 1));
		endcase
	endfunction

	initial begin
		int p;
		int goal;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		packet_start = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// nothing enabled: stray byte ignored, every start gives an empty header
		set_registers(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		settle();

		// everything at its widest
		set_registers(6'd63, 6'd33, 6'd33, 6'd32, 6'd32, 6'd15, 6'd31, 6'd31);
		push_byte(8'hF8, 1'b1);      // idle flag ends after the padding bits
		push_byte(8'h08, 1'b1);      // padding with zero padding bits
		push_byte(8'h00, 1'b1);      // no au start: ends after the clock reference
		repeat (4) push_byte(8'h00, 1'b0);
		push_byte(8'hC0, 1'b1);      // restart drops this header
		push_byte(8'hFF, 1'b0);
		push_byte(8'hF8, 1'b1);
		push_byte(8'h77, 1'b0);      // after the header: ignored
		settle();

		// time stamps flagged with zero-length stamps
		set_registers(6'd17, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
		push_byte(8'hE0, 1'b1);
		settle();

		for (p = 0; p < PHASES; p++) begin
			if (p == 0)
				set_registers(6'd63, 6'd33, 6'd33, 6'd32, 6'd32, 6'd15, 6'd31, 6'd31);
			else if (p == PHASES - 1)
				set_registers(6'd63, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1);
			else
				set_registers(6'($urandom_range(63)), pick_length(33), pick_length(33),
					pick_length(32), pick_length(32), pick_length(15), pick_length(31),
					pick_length(31));
			case (p % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					tx_idle_pct = 67;
					rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 67;
				end
				default: begin
					tx_idle_pct = 29;
					rx_stall_pct <= 29;
				end
			endcase
			// receiver holds off while bytes keep coming, so the parser backs up
			if (p == 0)
				hold_req <= 1'b1;
			goal = sent_items + PHASE_ITEMS;
			while (sent_items < goal) begin
				case ($urandom_range(19))
					0: push_byte(8'($urandom), 1'b0);
					1: begin
						push_byte(8'($urandom), 1'b1);
						repeat ($urandom_range(3)) push_byte(8'($urandom), 1'b0);
					end
					2: push_byte(8'($urandom), 1'b1);
					default: send_packet();
				endcase
			end
			settle();
		end

		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
